[design/svpwm_pkg.sv]
// shared constants, codes and types for the space vector pwm modulator
package svpwm_pkg;

	// sample and period widths
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int PERIOD_WIDTH     = 16;
	localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 16'd8192;

	// q1.15 projection constants
	localparam int FRAC_BITS      = 15;
	localparam int Q15_SQRT3_HALF = 28378;
	localparam int Q15_HALF_SHIFT = 14;

	// pipeline depths
	localparam int PROJ_STAGES = 3;
	localparam int MULT_STAGES = 1;
	localparam int DIV_STEPS   = PERIOD_WIDTH;
	localparam int DUTY_STAGES = 2;
	localparam int LATENCY     = PROJ_STAGES + MULT_STAGES + DIV_STEPS + DUTY_STAGES;

	// sector numbers
	typedef logic [2:0] sector_t;
	localparam sector_t SEC_ZERO = 3'd0;
	localparam sector_t SEC_1    = 3'd1;
	localparam sector_t SEC_2    = 3'd2;
	localparam sector_t SEC_3    = 3'd3;
	localparam sector_t SEC_4    = 3'd4;
	localparam sector_t SEC_5    = 3'd5;
	localparam sector_t SEC_6    = 3'd6;

	// projection sign patterns, {p1>0, p2>0, p3>0}
	localparam logic [2:0] CODE_S1 = 3'd5;
	localparam logic [2:0] CODE_S2 = 3'd4;
	localparam logic [2:0] CODE_S3 = 3'd6;
	localparam logic [2:0] CODE_S4 = 3'd2;
	localparam logic [2:0] CODE_S5 = 3'd3;
	localparam logic [2:0] CODE_S6 = 3'd1;

	// control group travelling with each sample
	typedef struct packed {
		logic    valid;
		sector_t sector;
		logic    ovm;
	} ctl_t;

endpackage

[design/svpwm_proj.sv]
// projections, rounding and sector selection, three register stages
module svpwm_proj #(
	parameter int W = svpwm_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic signed [W-1:0]                  alpha,
	input  logic signed [W-1:0]                  beta,
	input  logic [svpwm_pkg::PERIOD_WIDTH-1:0]   period,
	output svpwm_pkg::ctl_t                      ctl_out,
	output logic [W-1:0]                         t1_out,
	output logic [W-1:0]                         t2_out,
	output logic [svpwm_pkg::PERIOD_WIDTH-1:0]   period_out
);
	import svpwm_pkg::*;

	localparam int PW = W + 16;
	localparam int UW = W + 2;
	localparam logic [PW:0] ROUND_HALF = (PW+1)'(1) << (FRAC_BITS - 1);
	localparam logic signed [PW-1:0] K_EXT = PW'(Q15_SQRT3_HALF);

	// stage 1: input capture
	logic                    valid_s1;
	logic signed [W-1:0]     alpha_s1, beta_s1;
	logic [PERIOD_WIDTH-1:0] period_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		alpha_s1  <= alpha;
		beta_s1   <= beta;
		period_s1 <= period;
	end

	// stage 2: scaled projections
	logic signed [PW-1:0] a_ext, b_ext, ka, hb;
	logic signed [PW-1:0] proj_s2 [3];
	logic                 valid_s2;
	logic [PERIOD_WIDTH-1:0] period_s2;

	always_comb begin
		a_ext = {{(PW-W){alpha_s1[W-1]}}, alpha_s1};
		b_ext = {{(PW-W){beta_s1[W-1]}}, beta_s1};
		ka    = a_ext * K_EXT;
		hb    = b_ext <<< Q15_HALF_SHIFT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		proj_s2[0] <= b_ext <<< FRAC_BITS;
		proj_s2[1] <= -ka - hb;
		proj_s2[2] <= ka - hb;
		period_s2  <= period_s1;
	end

	// stage 3: round to counts, pick the sector pair
	logic [PW:0]          mag [3];
	logic [PW:0]          rnd [3];
	logic signed [UW-1:0] u   [3];
	logic [2:0]           code;
	logic signed [UW-1:0] x, y;
	sector_t              sec;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i]  = proj_s2[i][PW-1] ? -{proj_s2[i][PW-1], proj_s2[i]}
			                           : {1'b0, proj_s2[i]};
			rnd[i]  = (mag[i] + ROUND_HALF) >> FRAC_BITS;
			u[i]    = proj_s2[i][PW-1] ? -UW'(rnd[i]) : UW'(rnd[i]);
			code[2-i] = !proj_s2[i][PW-1] && (|proj_s2[i]);
		end
		case (code)
			CODE_S1: begin x = u[2];  y = u[0];  sec = SEC_1; end
			CODE_S2: begin x = -u[2]; y = -u[1]; sec = SEC_2; end
			CODE_S3: begin x = u[0];  y = u[1];  sec = SEC_3; end
			CODE_S4: begin x = -u[0]; y = -u[2]; sec = SEC_4; end
			CODE_S5: begin x = u[1];  y = u[2];  sec = SEC_5; end
			CODE_S6: begin x = -u[1]; y = -u[0]; sec = SEC_6; end
			default: begin x = '0;    y = '0;    sec = SEC_ZERO; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else begin
			ctl_out.valid  <= valid_s2;
			ctl_out.sector <= sec;
			ctl_out.ovm    <= 1'b0;
		end
	end

	// negative active times clip to zero
	always_ff @(posedge clk) begin
		t1_out     <= x[UW-1] ? '0 : x[W-1:0];
		t2_out     <= y[UW-1] ? '0 : y[W-1:0];
		period_out <= period_s2;
	end

endmodule

[design/svpwm_div.sv]
// overmodulation test and pipelined restoring division of t*period by t1+t2
module svpwm_div #(
	parameter int W = svpwm_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  svpwm_pkg::ctl_t                      ctl_in,
	input  logic [W-1:0]                         t1,
	input  logic [W-1:0]                         t2,
	input  logic [svpwm_pkg::PERIOD_WIDTH-1:0]   period,
	output svpwm_pkg::ctl_t                      ctl_out,
	output logic [svpwm_pkg::PERIOD_WIDTH-1:0]   t1_out,
	output logic [svpwm_pkg::PERIOD_WIDTH-1:0]   t2_out,
	output logic [svpwm_pkg::PERIOD_WIDTH-1:0]   period_out
);
	import svpwm_pkg::*;

	localparam int SW = W + 1;
	localparam int NW = W + PERIOD_WIDTH;
	localparam int CW = (SW > PERIOD_WIDTH) ? SW : PERIOD_WIDTH;
	localparam int QW = PERIOD_WIDTH;

	// per step registers, index is the step
	ctl_t                    ctl_s  [DIV_STEPS+1];
	logic [SW-1:0]           den_s  [DIV_STEPS+1];
	logic [PERIOD_WIDTH-1:0] per_s  [DIV_STEPS+1];
	logic [SW-1:0]           rem_s  [DIV_STEPS+1][2];
	logic [QW-1:0]           lo_s   [DIV_STEPS+1][2];
	logic [QW-1:0]           quo_s  [DIV_STEPS+1][2];
	logic [QW-1:0]           byp_s  [DIV_STEPS+1][2];

	// multiply stage: sum, overmodulation flag and numerators
	logic [SW-1:0] sum;
	logic          ovm;
	logic [NW-1:0] num [2];

	always_comb begin
		sum    = {1'b0, t1} + {1'b0, t2};
		ovm    = CW'(sum) > CW'(period);
		num[0] = NW'(t1) * NW'(period);
		num[1] = NW'(t2) * NW'(period);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else begin
			ctl_s[0].valid  <= ctl_in.valid;
			ctl_s[0].sector <= ctl_in.sector;
			ctl_s[0].ovm    <= ovm;
		end
	end

	always_ff @(posedge clk) begin
		den_s[0] <= sum;
		per_s[0] <= period;
		for (int l = 0; l < 2; l++) begin
			rem_s[0][l] <= {1'b0, num[l][NW-1:QW]};
			lo_s[0][l]  <= num[l][QW-1:0];
			quo_s[0][l] <= '0;
		end
		byp_s[0][0] <= QW'(t1);
		byp_s[0][1] <= QW'(t2);
	end

	// one quotient bit per step and lane
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [SW:0] trial [2];
		logic [SW:0] diff  [2];
		logic        fit   [2];

		always_comb begin
			for (int l = 0; l < 2; l++) begin
				trial[l] = {rem_s[k][l], lo_s[k][l][QW-1]};
				diff[l]  = trial[l] - {1'b0, den_s[k]};
				fit[l]   = trial[l] >= {1'b0, den_s[k]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			den_s[k+1] <= den_s[k];
			per_s[k+1] <= per_s[k];
			for (int l = 0; l < 2; l++) begin
				rem_s[k+1][l] <= fit[l] ? diff[l][SW-1:0] : trial[l][SW-1:0];
				lo_s[k+1][l]  <= {lo_s[k][l][QW-2:0], 1'b0};
				quo_s[k+1][l] <= {quo_s[k][l][QW-2:0], fit[l]};
				byp_s[k+1][l] <= byp_s[k][l];
			end
		end
	end

	// scaled times only when overmodulated
	assign ctl_out    = ctl_s[DIV_STEPS];
	assign period_out = per_s[DIV_STEPS];
	assign t1_out = ctl_s[DIV_STEPS].ovm ? quo_s[DIV_STEPS][0] : byp_s[DIV_STEPS][0];
	assign t2_out = ctl_s[DIV_STEPS].ovm ? quo_s[DIV_STEPS][1] : byp_s[DIV_STEPS][1];

endmodule

[design/svpwm_duty.sv]
// zero time split and phase compare values, two register stages
module svpwm_duty (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  svpwm_pkg::ctl_t                      ctl_in,
	input  logic [svpwm_pkg::PERIOD_WIDTH-1:0]   t1,
	input  logic [svpwm_pkg::PERIOD_WIDTH-1:0]   t2,
	input  logic [svpwm_pkg::PERIOD_WIDTH-1:0]   period,
	output logic                                 strobe,
	output logic [svpwm_pkg::PERIOD_WIDTH-1:0]   duty_a,
	output logic [svpwm_pkg::PERIOD_WIDTH-1:0]   duty_b,
	output logic [svpwm_pkg::PERIOD_WIDTH-1:0]   duty_c,
	output svpwm_pkg::sector_t                   sector,
	output logic                                 ovm
);
	import svpwm_pkg::*;

	localparam int PV = PERIOD_WIDTH;

	// stage 1: used time and half of the zero time
	logic [PV:0]   used;
	logic [PV-1:0] half;
	ctl_t          ctl_s1;
	logic [PV:0]   used_s1;
	logic [PV-1:0] half_s1, t2_s1, per_s1;

	always_comb begin
		used = {1'b0, t1} + {1'b0, t2};
		if (ctl_in.sector == SEC_ZERO) begin
			half = period >> 1;
		end else if (used > {1'b0, period}) begin
			half = '0;
		end else begin
			half = PV'(({1'b0, period} - used) >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		used_s1 <= used;
		half_s1 <= half;
		t2_s1   <= t2;
		per_s1  <= period;
	end

	// stage 2: clamp sums and route them to the phases
	logic [PV+1:0] full_w, one2_w;
	logic [PV-1:0] full_c, one2_c, half_c;
	logic [PV-1:0] da, db, dc;

	always_comb begin
		full_w = {1'b0, used_s1} + (PV+2)'(half_s1);
		one2_w = (PV+2)'(t2_s1) + (PV+2)'(half_s1);
		full_c = (full_w > (PV+2)'(per_s1)) ? per_s1 : full_w[PV-1:0];
		one2_c = (one2_w > (PV+2)'(per_s1)) ? per_s1 : one2_w[PV-1:0];
		half_c = (half_s1 > per_s1) ? per_s1 : half_s1;
		case (ctl_s1.sector)
			SEC_ZERO: begin da = half_c; db = half_c; dc = half_c; end
			SEC_1:    begin da = full_c; db = one2_c; dc = half_c; end
			SEC_2:    begin da = one2_c; db = full_c; dc = half_c; end
			SEC_3:    begin da = half_c; db = full_c; dc = one2_c; end
			SEC_4:    begin da = half_c; db = one2_c; dc = full_c; end
			SEC_5:    begin da = one2_c; db = half_c; dc = full_c; end
			default:  begin da = full_c; db = half_c; dc = one2_c; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
			sector <= SEC_ZERO;
			ovm    <= 1'b0;
		end else begin
			strobe <= ctl_s1.valid;
			sector <= ctl_s1.sector;
			ovm    <= ctl_s1.ovm && (ctl_s1.sector != SEC_ZERO);
		end
	end

	always_ff @(posedge clk) begin
		duty_a <= da;
		duty_b <= db;
		duty_c <= dc;
	end

endmodule

[design/space_vector_pwm_top.sv]
// top level of the space vector pwm modulator
// A new alpha/beta beat is taken on every cycle that start is high; busy is never raised.
// Each beat gives one result through 3 projection stages, 1 multiply
// stage, 16 restoring divider steps, one per quotient bit, and 2 duty stages, shown for
// one cycle with done high; the receiver cannot stall, so nothing queues inside. The
// period register is sampled with each beat; write it through cfg only while no beat is
// in flight. Duties are centre aligned counts in 0..period, a zero reference gives
// period/2 on every phase with sector 0.
module space_vector_pwm_top #(
	parameter int SAMPLE_WIDTH = svpwm_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [SAMPLE_WIDTH-1:0]       alpha_voltage,
	input  logic signed [SAMPLE_WIDTH-1:0]       beta_voltage,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [svpwm_pkg::PERIOD_WIDTH-1:0]   cfg_data,
	output logic                                 done,
	output logic [svpwm_pkg::PERIOD_WIDTH-1:0]   duty_a,
	output logic [svpwm_pkg::PERIOD_WIDTH-1:0]   duty_b,
	output logic [svpwm_pkg::PERIOD_WIDTH-1:0]   duty_c,
	output logic [2:0]                           sector_number,
	output logic                                 overmodulated
);
	import svpwm_pkg::*;

	// period register
	logic [PERIOD_WIDTH-1:0] period_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			period_q <= cfg_data;
		end
	end

	// projection front end
	ctl_t                    proj_ctl, div_ctl;
	logic [SAMPLE_WIDTH-1:0] proj_t1, proj_t2;
	logic [PERIOD_WIDTH-1:0] proj_per, div_t1, div_t2, div_per;

	svpwm_proj #(.W(SAMPLE_WIDTH)) u_proj (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (start && !busy),
		.alpha      (alpha_voltage),
		.beta       (beta_voltage),
		.period     (period_q),
		.ctl_out    (proj_ctl),
		.t1_out     (proj_t1),
		.t2_out     (proj_t2),
		.period_out (proj_per)
	);

	// overmodulation scaling
	svpwm_div #(.W(SAMPLE_WIDTH)) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_in     (proj_ctl),
		.t1         (proj_t1),
		.t2         (proj_t2),
		.period     (proj_per),
		.ctl_out    (div_ctl),
		.t1_out     (div_t1),
		.t2_out     (div_t2),
		.period_out (div_per)
	);

	// phase compare values
	svpwm_duty u_duty (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_in (div_ctl),
		.t1     (div_t1),
		.t2     (div_t2),
		.period (div_per),
		.strobe (done),
		.duty_a (duty_a),
		.duty_b (duty_b),
		.duty_c (duty_c),
		.sector (sector_number),
		.ovm    (overmodulated)
	);

	// every accepted beat comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("result strobe missing after accepted beat");

	// no result appears without a beat accepted the latency earlier
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without an accepted beat");

	// zero vector gives equal duties and no overmodulation
	a_zero_vector: assert property (@(posedge clk) disable iff (!arst_n)
		done && (sector_number == SEC_ZERO) |->
			!overmodulated && (duty_a == duty_b) && (duty_b == duty_c))
		else $error("zero vector result inconsistent");

	// sector code stays in range
	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (sector_number <= SEC_6))
		else $error("sector number out of range");

endmodule
